// File: sv/egc_pkg.sv
// Shared types and constants for the elevator group controller.
// No dependencies; every other file uses this package.
package egc_pkg;

  localparam int DEF_NUM_CARS   = 4;
  localparam int DEF_NUM_FLOORS = 16;

  // Fixed widths of the channel fields
  localparam int REQ_FLOOR_W = 4;
  localparam int IDX_W       = 2;
  localparam int CODE_W      = 2;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic REQ_CALL    = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    HEAD_UP   = 2'd0,
    HEAD_DOWN = 2'd1,
    HEAD_IDLE = 2'd2
  } heading_t;

  typedef enum logic [CODE_W-1:0] {
    MOT_IDLE    = 2'd0,
    MOT_MOVING  = 2'd1,
    MOT_STOPPED = 2'd2
  } motion_t;

  typedef struct packed {
    heading_t heading;
    motion_t  motion;
  } car_mode_t;

  typedef struct packed {
    car_mode_t mode;
    logic      arrived;
  } car_status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_QUEUE,
    OP_STEP
  } car_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCORE,
    ST_QUEUE,
    ST_STEP
  } ctrl_state_t;

endpackage

// File: sv/egc_channels.sv
// Valid/ready channel interfaces for request and status beats.
// Depends on egc_pkg for field widths.
interface egc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [egc_pkg::REQ_FLOOR_W-1:0] request_floor;

  modport source (output valid, req_type, request_floor, input ready);
  modport sink   (input valid, req_type, request_floor, output ready);
endinterface

interface egc_status_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [egc_pkg::IDX_W-1:0]       car_index;
  logic [egc_pkg::REQ_FLOOR_W-1:0] car_floor_now;
  logic [egc_pkg::CODE_W-1:0]      car_motion;
  logic [egc_pkg::CODE_W-1:0]      car_heading;
  logic                          arrived;
  logic                          last_result;

  modport source (output valid, result_kind, car_index, car_floor_now, car_motion,
                  car_heading, arrived, last_result, input ready);
  modport sink   (input valid, result_kind, car_index, car_floor_now, car_motion,
                  car_heading, arrived, last_result, output ready);
endinterface

// File: sv/egc_car_unit.sv
// Shared per-car unit: dispatch score, stop queueing and one SCAN step.
// Depends on egc_pkg; used once by the top level, one car per cycle unless the status sink stalls.
module egc_car_unit #(
  parameter int NUM_FLOORS = egc_pkg::DEF_NUM_FLOORS
) (
  input  egc_pkg::car_op_t                  op,
  input  logic [$clog2(NUM_FLOORS)-1:0]     req,
  input  logic [$clog2(NUM_FLOORS)-1:0]     floor,
  input  logic [NUM_FLOORS-1:0]             up,
  input  logic [NUM_FLOORS-1:0]             down,
  input  egc_pkg::car_mode_t                mode,
  output logic [$clog2(NUM_FLOORS):0]       score,
  output logic [$clog2(NUM_FLOORS)-1:0]     floor_next,
  output logic [NUM_FLOORS-1:0]             up_next,
  output logic [NUM_FLOORS-1:0]             down_next,
  output egc_pkg::car_status_t              status
);
  import egc_pkg::*;

  localparam int FW = $clog2(NUM_FLOORS);
  localparam logic [FW-1:0] TOP = FW'(NUM_FLOORS - 1);

  logic                  idle;
  logic [FW-1:0]         gap;
  logic [NUM_FLOORS-1:0] fbit, rbit, below, above;
  logic                  at_up, at_down;

  assign idle = (mode.heading != HEAD_UP) && (mode.heading != HEAD_DOWN) &&
                (up == '0) && (down == '0);
  assign gap   = (floor > req) ? floor - req : req - floor;
  // busy cars count double
  assign score = idle ? {1'b0, gap} : {gap, 1'b0};

  assign fbit  = NUM_FLOORS'(1) << floor;
  assign rbit  = NUM_FLOORS'(1) << req;
  assign below = fbit - NUM_FLOORS'(1);
  assign above = ~(below | fbit);
  // nearest stop in the travel direction sits at this floor
  assign at_up   = ((up & fbit) != '0) && ((up & below) == '0);
  assign at_down = ((down & fbit) != '0) && ((down & above) == '0);

  always_comb begin
    floor_next     = floor;
    up_next        = up;
    down_next      = down;
    status.mode    = mode;
    status.arrived = 1'b0;
    case (op)
      OP_QUEUE: begin
        if (req > floor) begin
          up_next = up | rbit;
          if (mode.heading != HEAD_UP && mode.heading != HEAD_DOWN)
            status.mode.heading = HEAD_UP;
        end else if (req < floor) begin
          down_next = down | rbit;
          if (mode.heading != HEAD_UP && mode.heading != HEAD_DOWN)
            status.mode.heading = HEAD_DOWN;
        end
      end
      OP_STEP: begin
        case (mode.heading)
          HEAD_UP: begin
            if (up == '0) begin
              status.mode.heading = (down != '0) ? HEAD_DOWN : HEAD_IDLE;
              status.mode.motion  = (down != '0) ? MOT_MOVING : MOT_IDLE;
            end else if (at_up) begin
              up_next            = up & ~fbit;
              status.mode.motion = MOT_STOPPED;
              status.arrived     = 1'b1;
            end else begin
              status.mode.motion = MOT_MOVING;
              if (floor < TOP) floor_next = floor + FW'(1);
            end
          end
          HEAD_DOWN: begin
            if (down == '0) begin
              status.mode.heading = (up != '0) ? HEAD_UP : HEAD_IDLE;
              status.mode.motion  = (up != '0) ? MOT_MOVING : MOT_IDLE;
            end else if (at_down) begin
              down_next          = down & ~fbit;
              status.mode.motion = MOT_STOPPED;
              status.arrived     = 1'b1;
            end else begin
              status.mode.motion = MOT_MOVING;
              if (floor != '0) floor_next = floor - FW'(1);
            end
          end
          default: status.mode.motion = MOT_IDLE;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: sv/elevator_group_controller.sv
// A call beat makes one scoring pass per car through the shared car unit, then
// queues the stop on the winner and loads the answer; a tick beat makes one SCAN
// step and one status beat per car. After either, the block returns to idle,
// where the next request is taken. Both are held up while the status sink holds
// ready low. The block takes no new request while it works, but a finished beat
// may wait in the output register.
// Depends on egc_pkg, egc_channels and egc_car_unit.
module elevator_group_controller #(
  parameter int NUM_CARS   = egc_pkg::DEF_NUM_CARS,
  parameter int NUM_FLOORS = egc_pkg::DEF_NUM_FLOORS
) (
  input  logic                clk,
  input  logic                rst,
  egc_cmd_if.sink             cmd,
  egc_status_if.source        status
);
  import egc_pkg::*;

  localparam int FW = $clog2(NUM_FLOORS);
  localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam logic [CW-1:0] LAST_CAR = CW'(NUM_CARS - 1);
  localparam logic [6:0]    TOP_WIDE = 7'(NUM_FLOORS - 1);

  // car state
  logic [FW-1:0]         car_floor [NUM_CARS];
  logic [NUM_FLOORS-1:0] car_up    [NUM_CARS];
  logic [NUM_FLOORS-1:0] car_down  [NUM_CARS];
  car_mode_t             car_mode  [NUM_CARS];

  ctrl_state_t   state, state_next;
  logic [CW-1:0] cnt, best, sel;
  logic [FW:0]   best_score;
  logic [FW-1:0] req;
  logic [6:0]    req_wide;

  car_op_t         op;
  logic            wr;
  logic            out_free;
  logic [FW:0]     score;
  logic [FW-1:0]   floor_next;
  logic [NUM_FLOORS-1:0] up_next, down_next;
  car_status_t     unit_st;

  // output register
  logic          out_valid;
  logic          out_kind;
  logic [CW-1:0] out_idx;
  logic [FW-1:0] out_floor;
  car_mode_t     out_mode;
  logic          out_arrived;
  logic          out_last;

  assign out_free = !out_valid || status.ready;
  assign req_wide = 7'(cmd.request_floor);

  egc_car_unit #(.NUM_FLOORS(NUM_FLOORS)) u_unit (
    .op         (op),
    .req        (req),
    .floor      (car_floor[sel]),
    .up         (car_up[sel]),
    .down       (car_down[sel]),
    .mode       (car_mode[sel]),
    .score      (score),
    .floor_next (floor_next),
    .up_next    (up_next),
    .down_next  (down_next),
    .status     (unit_st)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) state_next = (cmd.req_type == REQ_TICK) ? ST_STEP : ST_SCORE;
      end
      ST_SCORE: if (cnt == LAST_CAR) state_next = ST_QUEUE;
      ST_QUEUE: if (out_free) state_next = ST_IDLE;
      ST_STEP:  if (out_free && cnt == LAST_CAR) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    op        = OP_HOLD;
    wr        = 1'b0;
    sel       = cnt;
    case (state)
      ST_IDLE:  cmd.ready = 1'b1;
      ST_QUEUE: begin
        op  = OP_QUEUE;
        sel = best;
        wr  = out_free;
      end
      ST_STEP: begin
        op = OP_STEP;
        wr = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        car_floor[c] <= '0;
        car_up[c]    <= '0;
        car_down[c]  <= '0;
        car_mode[c]  <= '{heading: HEAD_IDLE, motion: MOT_IDLE};
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (cmd.valid) begin
            // clamp floors beyond the top
            req <= (req_wide > TOP_WIDE) ? FW'(TOP_WIDE) : FW'(req_wide);
          end
        end
        ST_SCORE: begin
          if (cnt == '0 || score < best_score) begin
            best_score <= score;
            best       <= cnt;
          end
          cnt <= cnt + CW'(1);
        end
        ST_STEP: if (out_free) cnt <= cnt + CW'(1);
        default: ;
      endcase
      if (wr) begin
        car_floor[sel] <= floor_next;
        car_up[sel]    <= up_next;
        car_down[sel]  <= down_next;
        car_mode[sel]  <= unit_st.mode;
        out_valid      <= 1'b1;
        out_idx        <= sel;
        out_mode       <= unit_st.mode;
        out_arrived    <= unit_st.arrived;
        if (state == ST_QUEUE) begin
          out_kind  <= KIND_ASSIGN;
          out_floor <= req;
          out_last  <= 1'b1;
        end else begin
          out_kind  <= KIND_STATUS;
          out_floor <= floor_next;
          out_last  <= (cnt == LAST_CAR);
        end
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.valid         = out_valid;
  assign status.result_kind   = out_kind;
  assign status.car_index     = IDX_W'(out_idx);
  assign status.car_floor_now = REQ_FLOOR_W'(out_floor);
  assign status.car_motion    = out_mode.motion;
  assign status.car_heading   = out_mode.heading;
  assign status.arrived       = out_arrived;
  assign status.last_result   = out_last;

endmodule

// File: sv/egc_checker.sv
// Port-level checks for the elevator group controller, bound to the top level.
// Depends on egc_pkg and elevator_group_controller.
module egc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          st_valid,
  input logic                          st_ready,
  input logic                          st_kind,
  input logic [egc_pkg::CODE_W-1:0]    st_motion,
  input logic                          st_arrived,
  input logic                          st_last,
  input logic [egc_pkg::IDX_W-1:0]     st_idx
);
  import egc_pkg::*;

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request accepted while previous one in progress");

  // while a tick sweep has more cars to report, no request is taken
  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    st_valid && st_kind == KIND_STATUS && !st_last |-> !cmd_ready)
    else $error("ready during unfinished tick sweep");

  a_assign_single: assert property (@(posedge clk) disable iff (rst)
    st_valid && st_kind == KIND_ASSIGN |-> st_last && !st_arrived)
    else $error("assignment beat must be single and not arrived");

  a_arrive_stopped: assert property (@(posedge clk) disable iff (rst)
    st_valid && st_arrived |-> st_motion == MOT_STOPPED)
    else $error("arrival without stopped motion");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st_ready |=> st_valid && $stable(st_idx) && $stable(st_last))
    else $error("stalled status beat changed");

endmodule

bind elevator_group_controller egc_checker u_egc_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .st_valid   (status.valid),
  .st_ready   (status.ready),
  .st_kind    (status.result_kind),
  .st_motion  (status.car_motion),
  .st_arrived (status.arrived),
  .st_last    (status.last_result),
  .st_idx     (status.car_index)
);

// File: tb/sv/elevator_group_controller_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for elevator_group_controller: drives call and tick beats,
// predicts car dispatch and SCAN stepping, and checks every status beat in order.
// Depends on egc_pkg, egc_channels and the controller RTL.
module elevator_group_controller_test;
  import egc_pkg::*;

  localparam int CARS   = DEF_NUM_CARS;
  localparam int FLOORS = DEF_NUM_FLOORS;
  localparam int MAX_PRINTED = 60;

  typedef struct {
    logic                   kind;
    logic [IDX_W-1:0]       car;
    logic [REQ_FLOOR_W-1:0] floor_now;
    motion_t                motion;
    heading_t               heading;
    logic                   arrived;
    logic                   last;
  } car_report_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   mismatches;

  // fleet state as the block should hold it
  logic [REQ_FLOOR_W-1:0] car_floor [CARS];
  logic [FLOORS-1:0]      up_stops [CARS];
  logic [FLOORS-1:0]      down_stops [CARS];
  heading_t               car_head [CARS];
  motion_t                car_mot [CARS];

  car_report_t pending_reports [$];

  egc_cmd_if    cmd_ch ();
  egc_status_if status_ch ();

  elevator_group_controller uut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .status (status_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #2_400_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("error at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Append one expected beat at the tail of the queue.
  function automatic void expect_report(input car_report_t rep);
    pending_reports = {pending_reports, rep};
  endfunction

  function automatic bit car_free(input int c);
    return car_head[c] != HEAD_UP && car_head[c] != HEAD_DOWN &&
           up_stops[c] == '0 && down_stops[c] == '0;
  endfunction

  function automatic int lowest_stop(input logic [FLOORS-1:0] stops);
    for (int i = 0; i < FLOORS; i++)
      if (stops[i]) return i;
    return -1;
  endfunction

  function automatic int highest_stop(input logic [FLOORS-1:0] stops);
    for (int i = FLOORS - 1; i >= 0; i--)
      if (stops[i]) return i;
    return -1;
  endfunction

  // Score every car, queue the stop on the winner, expect one assignment beat.
  function automatic void dispatch_call(input logic [REQ_FLOOR_W-1:0] req_floor);
    int          best;
    int          best_score;
    int          gap;
    int          score;
    int          target;
    car_report_t rep;
    target = req_floor;
    if (target > FLOORS - 1) target = FLOORS - 1;
    best = 0;
    best_score = 32'h7fff_ffff;
    for (int c = 0; c < CARS; c++) begin
      gap = (car_floor[c] > target) ? car_floor[c] - target : target - car_floor[c];
      score = car_free(c) ? gap : 2 * gap;
      if (score < best_score) begin
        best_score = score;
        best = c;
      end
    end
    if (target > car_floor[best]) begin
      up_stops[best][target] = 1'b1;
      if (car_head[best] != HEAD_UP && car_head[best] != HEAD_DOWN) car_head[best] = HEAD_UP;
    end else if (target < car_floor[best]) begin
      down_stops[best][target] = 1'b1;
      if (car_head[best] != HEAD_UP && car_head[best] != HEAD_DOWN)
        car_head[best] = HEAD_DOWN;
    end
    rep.kind      = KIND_ASSIGN;
    rep.car       = best[IDX_W-1:0];
    rep.floor_now = target[REQ_FLOOR_W-1:0];
    rep.motion    = car_mot[best];
    rep.heading   = car_head[best];
    rep.arrived   = 1'b0;
    rep.last      = 1'b1;
    expect_report(rep);
  endfunction

  // One SCAN step per car, one status beat per car.
  function automatic void step_fleet();
    car_report_t rep;
    logic        served;
    for (int c = 0; c < CARS; c++) begin
      served = 1'b0;
      case (car_head[c])
        HEAD_UP: begin
          if (up_stops[c] == '0) begin
            car_head[c] = (down_stops[c] != '0) ? HEAD_DOWN : HEAD_IDLE;
            car_mot[c]  = (down_stops[c] != '0) ? MOT_MOVING : MOT_IDLE;
          end else if (car_floor[c] == lowest_stop(up_stops[c])) begin
            up_stops[c][car_floor[c]] = 1'b0;
            car_mot[c] = MOT_STOPPED;
            served = 1'b1;
          end else begin
            car_mot[c] = MOT_MOVING;
            if (car_floor[c] < FLOORS - 1) car_floor[c]++;
          end
        end
        HEAD_DOWN: begin
          if (down_stops[c] == '0) begin
            car_head[c] = (up_stops[c] != '0) ? HEAD_UP : HEAD_IDLE;
            car_mot[c]  = (up_stops[c] != '0) ? MOT_MOVING : MOT_IDLE;
          end else if (car_floor[c] == highest_stop(down_stops[c])) begin
            down_stops[c][car_floor[c]] = 1'b0;
            car_mot[c] = MOT_STOPPED;
            served = 1'b1;
          end else begin
            car_mot[c] = MOT_MOVING;
            if (car_floor[c] > 0) car_floor[c]--;
          end
        end
        default: begin
          car_mot[c] = MOT_IDLE;
        end
      endcase
      rep.kind      = KIND_STATUS;
      rep.car       = c[IDX_W-1:0];
      rep.floor_now = car_floor[c];
      rep.motion    = car_mot[c];
      rep.heading   = car_head[c];
      rep.arrived   = served;
      rep.last      = (c == CARS - 1);
      expect_report(rep);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic kind, input logic [REQ_FLOOR_W-1:0] req_floor);
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.req_type      <= kind;
    cmd_ch.request_floor <= req_floor;
    do @(posedge clk); while (!cmd_ch.ready);
    if (kind == REQ_TICK) step_fleet();
    else dispatch_call(req_floor);
    @(negedge clk);
  endtask

  task automatic send_call(input int req_floor);
    send_beat(REQ_CALL, req_floor[REQ_FLOOR_W-1:0]);
  endtask

  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) send_beat(REQ_TICK, REQ_FLOOR_W'($urandom));
  endtask

  task automatic apply_reset();
    for (int c = 0; c < CARS; c++) begin
      car_floor[c]  = '0;
      up_stops[c]   = '0;
      down_stops[c] = '0;
      car_head[c]   = HEAD_IDLE;
      car_mot[c]    = MOT_IDLE;
    end
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
  endtask

  // Own-floor calls, ties, busy doubling, both ends of the shaft, stops behind a car.
  task automatic run_directed_calls();
    send_call(0);
    send_ticks(1);
    send_call(FLOORS - 1);
    send_call(FLOORS - 1);
    send_call(0);
    send_call(7);
    send_ticks(3);
    send_call(1);
    send_call(2);
    send_ticks(2);
    send_call(8);
    send_call(FLOORS - 1);
    send_ticks(6);
    send_call(0);
    send_call(5);
    send_ticks(4);
  endtask

  // Mostly bursts of calls followed by runs of ticks; some loose random beats.
  task automatic run_scan_traffic(input int n_items);
    int sent;
    int calls;
    int ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        calls = $urandom_range(1, 3);
        ticks = $urandom_range(2, 16);
        for (int i = 0; i < calls; i++) send_call($urandom_range(FLOORS - 1));
        send_ticks(ticks);
        sent += calls + ticks;
      end else begin
        send_beat(logic'($urandom_range(1)), REQ_FLOOR_W'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_unstalled_stretch(input int n_items);
    no_idle = 1'b1;
    run_scan_traffic(n_items);
    no_idle = 1'b0;
  endtask

  task automatic drain_and_finish();
    cmd_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3 * CARS + 10) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  endtask

  always @(negedge clk)
    status_ch.ready <= no_idle || ($urandom_range(99) >= 23);

  always @(posedge clk) begin : check_reports
    car_report_t want;
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("status beat with nothing expected, car %0d",
                                  status_ch.car_index));
      end else begin
        want = pending_reports.pop_front();
        if (status_ch.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %b, want %b", status_ch.result_kind,
                                    want.kind));
        if (status_ch.car_index !== want.car)
          report_mismatch($sformatf("car_index %0d, want %0d", status_ch.car_index,
                                    want.car));
        if (status_ch.car_floor_now !== want.floor_now)
          report_mismatch($sformatf("car %0d floor %0d, want %0d", want.car,
                                    status_ch.car_floor_now, want.floor_now));
        if (status_ch.car_motion !== want.motion)
          report_mismatch($sformatf("car %0d motion %0d, want %0d", want.car,
                                    status_ch.car_motion, want.motion));
        if (status_ch.car_heading !== want.heading)
          report_mismatch($sformatf("car %0d heading %0d, want %0d", want.car,
                                    status_ch.car_heading, want.heading));
        if (status_ch.arrived !== want.arrived)
          report_mismatch($sformatf("car %0d arrived %b, want %b", want.car,
                                    status_ch.arrived, want.arrived));
        if (status_ch.last_result !== want.last)
          report_mismatch($sformatf("car %0d last_result %b, want %b", want.car,
                                    status_ch.last_result, want.last));
      end
    end
  end

  initial begin
    mismatches           = 0;
    no_idle              = 1'b0;
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.req_type      = REQ_CALL;
    cmd_ch.request_floor = '0;
    status_ch.ready      = 1'b0;
    apply_reset();
    run_directed_calls();
    run_scan_traffic(160);
    run_unstalled_stretch(100);
    run_scan_traffic(170);
    drain_and_finish();
  end

endmodule
